// ----- rtl/awat_pkg.sv -----
// Shared types, constants and the cos^2 table for the window average and tilt block.
`timescale 1ns / 1ps

package awat_pkg;

  localparam int GAIN_W        = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int OP_W          = 2;
  localparam int SPEED_W       = 2;
  localparam int AVG_W         = 8;
  localparam int TILT_W        = 7;
  localparam int CNT_W         = 5;
  localparam int REM_W         = 6;
  localparam int COS_W         = 33;
  localparam int COS_FRAC      = 32;
  localparam int TAB_IDX_W     = 7;
  localparam int TAB_DEPTH     = 128;
  localparam int DEG_MAX       = 90;
  localparam int SERIES_TERMS  = 30;
  localparam int SEARCH_TOP    = 6;

  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] DEG_STEP_Q60 = PI_Q60 / 64'd180;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd6;

  localparam logic [OP_W-1:0] OP_AVG  = 2'd0;
  localparam logic [OP_W-1:0] OP_TILT = 2'd1;
  localparam logic [OP_W-1:0] OP_BOTH = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [SPEED_W-1:0] SPEED_SLOW = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_MID  = 2'd1;

  localparam logic [CNT_W-1:0] WIN_SLOW = 5'd30;
  localparam logic [CNT_W-1:0] WIN_MID  = 5'd20;
  localparam logic [CNT_W-1:0] WIN_FAST = 5'd10;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd16384;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_SQ,
    MUL_COS
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_P_GO,
    ST_P_WAIT,
    ST_ZCHK,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_SR_INIT,
    ST_SR_GO,
    ST_SR_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic       div_cap;
    logic       mul_start;
    mul_sel_t   mul_sel;
    logic       cap_p;
    logic       zero_cap;
    logic       cap_sq;
    logic       srch_init;
    logic       srch_step;
    logic       load_out;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic win_full;
    logic avg_en;
    logic tilt_en;
    logic div_done;
    logic mul_done;
    logic p_zero;
    logic t_over;
    logic b_last;
    logic out_busy;
  } dp_sts_t;

  typedef logic [COS_W-1:0] cos2_tab_t [0:TAB_DEPTH-1];

  // Restoring long division; it only runs while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos^2(k deg) in Q0.32, rounded to nearest, from a Q60 Taylor series of cos.
  function automatic cos2_tab_t build_cos2();
    cos2_tab_t   tab;
    logic [127:0] prod;
    logic [63:0]  step;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  c;
    logic [63:0]  dv;
    tab  = '{default: '0};
    step = DEG_STEP_Q60;
    for (int k = 1; k <= DEG_MAX; k++) begin
      x    = 64'(k) * step;
      prod = {64'd0, x} * {64'd0, x};
      x2   = prod[123:60];
      term = 64'h1000_0000_0000_0000;
      c    = term;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        prod = {64'd0, term} * {64'd0, x2};
        dv   = 64'((2 * n - 1) * (2 * n));
        term = udiv64(prod[123:60], dv);
        if ((n & 1) == 1) begin
          c = c - term;
        end else begin
          c = c + term;
        end
      end
      // A tiny negative residue near 90 degrees wraps to a huge value.
      if (c > 64'h4000_0000_0000_0000) begin
        c = '0;
      end
      prod   = {64'd0, c} * {64'd0, c};
      tab[k] = COS_W'((prod[127:64] + 64'h0000_0000_0080_0000) >> 24);
    end
    return tab;
  endfunction

  localparam cos2_tab_t COS2_TAB = build_cos2();

endpackage

// ----- rtl/awat_ctrl.sv -----
// Controller state machine that sequences accumulation, averaging and the tilt search.
`timescale 1ns / 1ps

module awat_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  awat_pkg::dp_sts_t sts,
  output awat_pkg::dp_cmd_t cmd
);
  import awat_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.axis  = ax_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ax_nxt = '0;
        if (!sts.win_full) begin
          state_nxt = ST_IDLE;
        end else if (sts.avg_en) begin
          state_nxt = ST_DIV_GO;
        end else if (sts.tilt_en) begin
          state_nxt = ST_P_GO;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          if (ax_r == AXIS_LAST) begin
            ax_nxt    = '0;
            state_nxt = sts.tilt_en ? ST_P_GO : ST_OUT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_P_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_GAIN;
        state_nxt     = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (sts.mul_done) begin
          cmd.cap_p = 1'b1;
          if (ax_r == AXIS_LAST) begin
            ax_nxt    = '0;
            state_nxt = ST_ZCHK;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = ST_P_GO;
          end
        end
      end
      ST_ZCHK: begin
        cmd.zero_cap = 1'b1;
        state_nxt    = sts.p_zero ? ST_OUT : ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_SQ;
        state_nxt     = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (sts.mul_done) begin
          cmd.cap_sq = 1'b1;
          if (ax_r == AXIS_LAST) begin
            ax_nxt    = '0;
            state_nxt = ST_SR_INIT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = ST_SQ_GO;
          end
        end
      end
      ST_SR_INIT: begin
        cmd.srch_init = 1'b1;
        state_nxt     = ST_SR_GO;
      end
      ST_SR_GO, ST_SR_WAIT: begin
        // A candidate past 90 degrees fails without a multiply.
        if ((state_r == ST_SR_GO && sts.t_over) || (state_r == ST_SR_WAIT && sts.mul_done)) begin
          cmd.srch_step = 1'b1;
          if (!sts.b_last) begin
            state_nxt = ST_SR_GO;
          end else if (ax_r == AXIS_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = ST_SR_INIT;
          end
        end else if (state_r == ST_SR_GO) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_COS;
          state_nxt     = ST_SR_WAIT;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/awat_datapath.sv -----
// Datapath: configuration registers, sums, divider, shift-add multiplier, search and result register.
`timescale 1ns / 1ps

module awat_datapath #(
  parameter int SUM_WIDTH    = 16,
  parameter int SAMPLE_WIDTH = 13
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  awat_pkg::dp_cmd_t                      cmd,
  output awat_pkg::dp_sts_t                      sts,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_y,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_z,
  input  logic [awat_pkg::OP_W-1:0]              in_opcode,
  input  logic                                  cfg_valid,
  input  logic [awat_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [awat_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_x,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_y,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_z,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_x,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_y,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_z,
  output logic                                  out_avg_valid,
  output logic                                  out_tilt_valid,
  output logic                                  out_zero_vector
);
  import awat_pkg::*;

  localparam int PW   = SUM_WIDTH + GAIN_W;
  localparam int SQW  = 2 * PW;
  localparam int TW   = SQW + 2;
  localparam int RW   = TW + COS_W;
  localparam int MPW  = (PW > COS_W) ? PW : COS_W;
  localparam int AW   = (SUM_WIDTH > SAMPLE_WIDTH + 1) ? SUM_WIDTH : SAMPLE_WIDTH + 1;
  localparam int DCW  = $clog2(SUM_WIDTH + 1);

  // Configuration.
  logic [SAMPLE_WIDTH-1:0] offset_r [3];
  logic [GAIN_W-1:0]       gain_r [3];
  logic [SPEED_W-1:0]      speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        offset_r[i] <= '0;
        gain_r[i]   <= GAIN_ONE;
      end
      speed_r <= SPEED_SLOW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_r[0] <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_OFFSET_Y: offset_r[1] <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_OFFSET_Z: offset_r[2] <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_GAIN_X:   gain_r[0]   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:   gain_r[1]   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Z:   gain_r[2]   <= cfg_data[GAIN_W-1:0];
        REG_SPEED:    speed_r     <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] win_len;

  always_comb begin
    if (speed_r == SPEED_SLOW) begin
      win_len = WIN_SLOW;
    end else if (speed_r == SPEED_MID) begin
      win_len = WIN_MID;
    end else begin
      win_len = WIN_FAST;
    end
  end

  // Accumulation.
  logic [SAMPLE_WIDTH-1:0]        samp [3];
  logic signed [SAMPLE_WIDTH:0]   dif [3];
  logic [SAMPLE_WIDTH:0]          mag [3];
  logic [AW-1:0]                  sum_ext [3];
  logic [SUM_WIDTH-1:0]           sum_r [3];
  logic [CNT_W-1:0]               cnt_r;
  logic [OP_W-1:0]                op_r;

  always_comb begin
    samp[0] = in_sample_x;
    samp[1] = in_sample_y;
    samp[2] = in_sample_z;
    for (int i = 0; i < 3; i++) begin
      dif[i]     = {samp[i][SAMPLE_WIDTH-1], samp[i]}
                 - {offset_r[i][SAMPLE_WIDTH-1], offset_r[i]};
      mag[i]     = dif[i][SAMPLE_WIDTH] ? (~dif[i] + 1'b1) : dif[i];
      sum_ext[i] = AW'(sum_r[i]) + AW'(mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
      cnt_r <= '0;
    end else if (cmd.accept) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_ext[i][SUM_WIDTH-1:0];
      end
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.load_out) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_opcode;
    end
  end

  // Restoring divider by the window length, one quotient bit a cycle.
  logic [SUM_WIDTH-1:0] div_q_r;
  logic [REM_W-1:0]     div_rem_r;
  logic [DCW-1:0]       div_cnt_r;
  logic [REM_W-1:0]     div_trial;
  logic                 div_ge;
  logic [AVG_W-1:0]     avg_r [3];

  always_comb begin
    div_trial = {div_rem_r[REM_W-2:0], div_q_r[SUM_WIDTH-1]};
    div_ge    = div_trial >= REM_W'(win_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DCW'(SUM_WIDTH);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q_r   <= sum_r[cmd.axis];
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      div_q_r   <= {div_q_r[SUM_WIDTH-2:0], div_ge};
      div_rem_r <= div_ge ? (div_trial - REM_W'(win_len)) : div_trial;
    end
    if (cmd.div_cap) begin
      avg_r[cmd.axis] <= div_q_r[AVG_W-1:0];
    end
  end

  // Shift-add multiplier shared by the gain products, squares and table products.
  logic [RW-1:0]        mc_r;
  logic [MPW-1:0]       mp_r;
  logic [RW-1:0]        acc_r;
  logic [PW-1:0]        p_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic [TW-1:0]        tot_r;
  logic                 zero_r;
  logic [TAB_IDX_W-1:0] c_r;
  logic [2:0]           b_r;
  logic [TAB_IDX_W-1:0] cand;
  logic [TAB_IDX_W-1:0] c_nxt;
  logic [RW-1:0]        left;
  logic                 t_over;
  logic [TILT_W-1:0]    tilt_r [3];

  always_comb begin
    cand   = c_r | (TAB_IDX_W'(1) << b_r);
    t_over = cand > TAB_IDX_W'(DEG_MAX);
    left   = RW'(sq_r[cmd.axis]) << COS_FRAC;
    c_nxt  = (!t_over && (left <= acc_r)) ? cand : c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= '0;
    end else if (cmd.mul_start) begin
      case (cmd.mul_sel)
        MUL_GAIN: mp_r <= MPW'(gain_r[cmd.axis]);
        MUL_SQ:   mp_r <= MPW'(p_r[cmd.axis]);
        MUL_COS:  mp_r <= MPW'(COS2_TAB[cand]);
        default:  mp_r <= '0;
      endcase
    end else if (mp_r != '0) begin
      mp_r <= mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc_r <= '0;
      case (cmd.mul_sel)
        MUL_GAIN: mc_r <= RW'(sum_r[cmd.axis]);
        MUL_SQ:   mc_r <= RW'(p_r[cmd.axis]);
        MUL_COS:  mc_r <= RW'(tot_r);
        default:  mc_r <= '0;
      endcase
    end else if (mp_r != '0) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_p) begin
      p_r[cmd.axis] <= acc_r[PW-1:0];
    end
    if (cmd.zero_cap) begin
      zero_r <= sts.p_zero;
      tot_r  <= '0;
    end else if (cmd.cap_sq) begin
      tot_r <= tot_r + TW'(acc_r[SQW-1:0]);
    end
    if (cmd.cap_sq) begin
      sq_r[cmd.axis] <= acc_r[SQW-1:0];
    end
    // The count is built one bit a step, most significant first.
    if (cmd.srch_init) begin
      c_r <= '0;
      b_r <= 3'(SEARCH_TOP);
    end else if (cmd.srch_step) begin
      c_r <= c_nxt;
      b_r <= b_r - 1'b1;
      if (b_r == '0) begin
        tilt_r[cmd.axis] <= TILT_W'(DEG_MAX) - c_nxt;
      end
    end
  end

  // Result register.
  logic avg_en;
  logic tilt_en;

  assign avg_en  = (op_r == OP_AVG) || (op_r == OP_BOTH);
  assign tilt_en = (op_r == OP_TILT) || (op_r == OP_BOTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_avg_x       <= avg_en ? avg_r[0] : '0;
      out_avg_y       <= avg_en ? avg_r[1] : '0;
      out_avg_z       <= avg_en ? avg_r[2] : '0;
      out_tilt_x      <= (tilt_en && !zero_r) ? tilt_r[0] : '0;
      out_tilt_y      <= (tilt_en && !zero_r) ? tilt_r[1] : '0;
      out_tilt_z      <= (tilt_en && !zero_r) ? tilt_r[2] : '0;
      out_avg_valid   <= avg_en;
      out_tilt_valid  <= tilt_en;
      out_zero_vector <= tilt_en && zero_r;
    end
  end

  always_comb begin
    sts.win_full = cnt_r >= win_len;
    sts.avg_en   = avg_en;
    sts.tilt_en  = tilt_en;
    sts.div_done = div_cnt_r == '0;
    sts.mul_done = mp_r == '0;
    sts.p_zero   = (p_r[0] == '0) && (p_r[1] == '0) && (p_r[2] == '0);
    sts.t_over   = t_over;
    sts.b_last   = b_r == '0;
    sts.out_busy = out_valid;
  end

endmodule

// ----- rtl/accel_window_average_and_tilt.sv -----
// Top level of the accelerometer window average and tilt block.
`timescale 1ns / 1ps

// Each input item is one three-axis sample; its offset-corrected magnitude is added
// into a per-axis wrapping sum. The input stalls until the item's work is done.
// The item that closes a window of 30, 20 or 10 samples (speed register) starts the
// window-end work, whose length is set by the single shift-add multiplier and the
// bit-serial divider: the three averages, the gain products and squares, and up to 21
// table products for the bit-by-bit arccos search.
// A finished result waits in an output register while the next items are taken; a
// second window end waits only if that register is still full. Configuration is
// written through a port that is always ready.
module accel_window_average_and_tilt #(
  parameter int SUM_WIDTH    = 16,
  parameter int SAMPLE_WIDTH = 13
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_y,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_z,
  input  logic [awat_pkg::OP_W-1:0]              in_opcode,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_x,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_y,
  output logic [awat_pkg::AVG_W-1:0]             out_avg_z,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_x,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_y,
  output logic [awat_pkg::TILT_W-1:0]            out_tilt_z,
  output logic                                  out_avg_valid,
  output logic                                  out_tilt_valid,
  output logic                                  out_zero_vector,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [awat_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [awat_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import awat_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  awat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  awat_datapath #(
    .SUM_WIDTH    (SUM_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_x     (in_sample_x),
    .in_sample_y     (in_sample_y),
    .in_sample_z     (in_sample_z),
    .in_opcode       (in_opcode),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_avg_x       (out_avg_x),
    .out_avg_y       (out_avg_y),
    .out_avg_z       (out_avg_z),
    .out_tilt_x      (out_tilt_x),
    .out_tilt_y      (out_tilt_y),
    .out_tilt_z      (out_tilt_z),
    .out_avg_valid   (out_avg_valid),
    .out_tilt_valid  (out_tilt_valid),
    .out_zero_vector (out_zero_vector)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the accelerometer window average and tilt block.
`timescale 1ns / 1ps

module tb_top;
  import awat_pkg::*;

  localparam int SW = 13;

  typedef struct {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    logic [OP_W-1:0]      op;
  } sample_item_t;

  typedef struct {
    logic [AVG_W-1:0]  ax, ay, az;
    logic [TILT_W-1:0] tx, ty, tz;
    logic              av, tv, zv;
  } window_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SW-1:0] in_sample_x, in_sample_y, in_sample_z;
  logic [OP_W-1:0] in_opcode;
  logic out_valid;
  logic out_stall;
  logic [AVG_W-1:0] out_avg_x, out_avg_y, out_avg_z;
  logic [TILT_W-1:0] out_tilt_x, out_tilt_y, out_tilt_z;
  logic out_avg_valid, out_tilt_valid, out_zero_vector;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  accel_window_average_and_tilt uut (.*);

  // Predictor state and configuration copy.
  logic [63:0] cos_sq [0:90];
  logic signed [SW-1:0] off_x, off_y, off_z;
  logic [15:0] gn_x, gn_y, gn_z;
  logic [1:0] speed;
  logic [15:0] acc_x, acc_y, acc_z;
  logic [4:0] taken;

  sample_item_t pending_q[$];
  window_res_t  window_results_q[$];
  sample_item_t cur;
  int gap_left;
  int stall_left;
  bit no_idle;
  int errors;
  int n_items;
  int n_windows;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("CHECK FAILED");
    $finish;
  end

  // cos^2(k deg) in Q0.32 from a Q60 power series of cos.
  task automatic build_cos_sq();
    logic [127:0] prod;
    logic [63:0] step, x, x2, term, c;
    step = 64'h3243_F6A8_885A_308D / 64'd180;
    cos_sq[0] = 64'd1 << 32;
    for (int k = 1; k <= 90; k++) begin
      x = 64'(k) * step;
      prod = {64'd0, x} * {64'd0, x};
      x2 = prod[123:60];
      term = 64'd1 << 60;
      c = term;
      for (int n = 1; n <= 30; n++) begin
        prod = {64'd0, term} * {64'd0, x2};
        term = prod[123:60] / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) c = c - term;
        else c = c + term;
      end
      if (c > (64'd1 << 62)) c = '0;
      prod = {64'd0, c} * {64'd0, c};
      cos_sq[k] = (prod[127:64] + (64'd1 << 23)) >> 24;
    end
  endtask

  function automatic logic [TILT_W-1:0] tilt_deg(logic [31:0] p, logic [127:0] total);
    logic [127:0] lhs, rhs;
    int cnt;
    cnt = 0;
    lhs = ({96'd0, p} * {96'd0, p}) << 32;
    for (int k = 1; k <= 90; k++) begin
      rhs = {64'd0, cos_sq[k]} * total;
      if (lhs <= rhs) cnt++;
    end
    return TILT_W'(90 - cnt);
  endfunction

  function automatic logic [15:0] mag(logic signed [SW-1:0] s, logic signed [SW-1:0] o);
    int d;
    d = int'(s) - int'(o);
    if (d < 0) d = -d;
    return 16'(d);
  endfunction

  // Accumulate one accepted sample; queue a result when the window closes.
  task automatic accumulate(sample_item_t it);
    window_res_t r;
    int n;
    logic [31:0] px, py, pz;
    logic [127:0] total;
    acc_x = acc_x + mag(it.sx, off_x);
    acc_y = acc_y + mag(it.sy, off_y);
    acc_z = acc_z + mag(it.sz, off_z);
    taken = taken + 5'd1;
    n = (speed == SPEED_SLOW) ? 30 : (speed == SPEED_MID) ? 20 : 10;
    if (int'(taken) < n) return;
    r = '{default: '0};
    if (it.op == OP_AVG || it.op == OP_BOTH) begin
      r.ax = AVG_W'(acc_x / n);
      r.ay = AVG_W'(acc_y / n);
      r.az = AVG_W'(acc_z / n);
      r.av = 1'b1;
    end
    if (it.op == OP_TILT || it.op == OP_BOTH) begin
      px = {16'd0, acc_x} * {16'd0, gn_x};
      py = {16'd0, acc_y} * {16'd0, gn_y};
      pz = {16'd0, acc_z} * {16'd0, gn_z};
      r.tv = 1'b1;
      if (px == 0 && py == 0 && pz == 0) begin
        r.zv = 1'b1;
      end else begin
        total = {96'd0, px} * {96'd0, px} + {96'd0, py} * {96'd0, py}
              + {96'd0, pz} * {96'd0, pz};
        r.tx = tilt_deg(px, total);
        r.ty = tilt_deg(py, total);
        r.tz = tilt_deg(pz, total);
      end
    end
    window_results_q.push_back(r);
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    taken = '0;
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Driver: one item in flight, a random gap drawn after each item.
  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        accumulate(cur);
        n_items++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_sample_x <= cur.sx;
          in_sample_y <= cur.sy;
          in_sample_z <= cur.sz;
          in_opcode <= cur.op;
          gap_left <= no_idle ? 0 : $urandom_range(0, 7);
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Monitor: random stall per result, field-by-field compare.
  always @(posedge clk) begin
    window_res_t w;
    int s;
    s = stall_left;
    if (rst_n && out_valid && !out_stall) begin
      if (window_results_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = window_results_q.pop_front();
        n_windows++;
        if (out_avg_x != w.ax) report("avg_x", out_avg_x, w.ax);
        if (out_avg_y != w.ay) report("avg_y", out_avg_y, w.ay);
        if (out_avg_z != w.az) report("avg_z", out_avg_z, w.az);
        if (out_tilt_x != w.tx) report("tilt_x", out_tilt_x, w.tx);
        if (out_tilt_y != w.ty) report("tilt_y", out_tilt_y, w.ty);
        if (out_tilt_z != w.tz) report("tilt_z", out_tilt_z, w.tz);
        if (out_avg_valid != w.av) report("avg_valid", out_avg_valid, w.av);
        if (out_tilt_valid != w.tv) report("tilt_valid", out_tilt_valid, w.tv);
        if (out_zero_vector != w.zv) report("zero_vector", out_zero_vector, w.zv);
      end
      s = no_idle ? 0 : $urandom_range(0, 7);
    end else if (s > 0) begin
      s = s - 1;
    end
    stall_left <= s;
    out_stall <= (s > 0);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OFFSET_X: off_x = data[SW-1:0];
      REG_OFFSET_Y: off_y = data[SW-1:0];
      REG_OFFSET_Z: off_z = data[SW-1:0];
      REG_GAIN_X:   gn_x = data;
      REG_GAIN_Y:   gn_y = data;
      REG_GAIN_Z:   gn_z = data;
      REG_SPEED:    speed = data[1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic push_item(int x, int y, int z, logic [OP_W-1:0] op);
    sample_item_t it;
    it.sx = SW'(x);
    it.sy = SW'(y);
    it.sz = SW'(z);
    it.op = op;
    pending_q.push_back(it);
  endtask

  // Wait until the block has taken everything and delivered every result.
  task automatic drain();
    do @(posedge clk); while (pending_q.size() > 0 || in_valid);
    do @(posedge clk); while (window_results_q.size() > 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return {3'($urandom), 13'h1000};
      1: return {3'($urandom), 13'h0FFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return GAIN_ONE;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int near(logic signed [SW-1:0] o);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 8191);
    return int'(o) + $urandom_range(0, 40) - 20;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_z = '0;
    in_opcode = OP_AVG;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_OFFSET_X;
    cfg_data = '0;
    stall_left = 0;
    gap_left = 0;
    no_idle = 1'b0;
    errors = 0;
    n_items = 0;
    n_windows = 0;
    n_cfg = 0;
    off_x = '0; off_y = '0; off_z = '0;
    gn_x = GAIN_ONE; gn_y = GAIN_ONE; gn_z = GAIN_ONE;
    speed = SPEED_SLOW;
    acc_x = '0; acc_y = '0; acc_z = '0;
    taken = '0;
    build_cos_sq();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ten-sample windows, a zero vector, then full-scale extremes.
    write_reg(REG_SPEED, 16'd2);
    for (int i = 0; i < 9; i++) push_item(0, 0, 0, OP_NONE);
    push_item(0, 0, 0, OP_TILT);
    for (int i = 0; i < 9; i++)
      push_item(i % 2 ? 4095 : -4096, i % 2 ? -4096 : 4095, -4096, OP_AVG);
    push_item(4095, -4096, 4095, OP_BOTH);
    drain();
    // Extreme offsets and gains; speed three behaves as ten samples.
    write_reg(REG_OFFSET_X, 16'h1000);
    write_reg(REG_OFFSET_Y, 16'hEFFF);
    write_reg(REG_OFFSET_Z, 16'h0000);
    write_reg(REG_GAIN_X, 16'hFFFF);
    write_reg(REG_GAIN_Y, 16'h0000);
    write_reg(REG_GAIN_Z, 16'h0001);
    write_reg(REG_SPEED, 16'hFFFF);
    for (int i = 0; i < 10; i++)
      push_item(4095, -4096, i, OP_AVG + OP_W'(i % 4));
    drain();

    // Random phases; a partial window left open shows a shrunk window on the next speed.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_OFFSET_X, pick_offset());
      write_reg(REG_OFFSET_Y, pick_offset());
      write_reg(REG_OFFSET_Z, pick_offset());
      write_reg(REG_GAIN_X, pick_gain());
      write_reg(REG_GAIN_Y, pick_gain());
      write_reg(REG_GAIN_Z, pick_gain());
      write_reg(REG_SPEED, 16'($urandom_range(0, 3)));
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 158; i++)
        push_item(near(off_x), near(off_y), near(off_z), OP_W'($urandom_range(0, 3)));
      drain();
    end

    $display("%0d samples taken, %0d window results checked, %0d register writes",
             n_items, n_windows, n_cfg);
    $display("covered all modes, speeds incl. three, extreme offsets and gains, zero vector");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/awat_pkg.sv
rtl/awat_ctrl.sv
rtl/awat_datapath.sv
rtl/accel_window_average_and_tilt.sv
dv/tb_top.sv
